@@ rtl/sst_pkg.sv @@
`default_nettype none

package sst_pkg;

	typedef enum logic [1:0] {
		KIND_ADD     = 2'd0,
		KIND_DELETE  = 2'd1,
		KIND_READ    = 2'd2,
		KIND_REPLACE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_DUP   = 2'd1,
		STATUS_RANGE = 2'd2,
		STATUS_FULL  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_FETCH,
		ST_COMPARE,
		ST_APPLY,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic ins;
		logic del;
		logic wr;
	} sst_op_t;

endpackage

`default_nettype wire

@@ rtl/sst_cell.sv @@
`default_nettype none

module sst_cell #(
	parameter int CNT_W     = 9,
	parameter int KEY_WIDTH = 32,
	parameter int MY_IDX    = 0
) (
	input  wire logic                 clk,
	input  wire sst_pkg::sst_op_t     op,
	input  wire logic [CNT_W-1:0]     pos,
	input  wire logic [CNT_W-1:0]     cnt,
	input  wire logic [KEY_WIDTH-1:0] key_in,
	input  wire logic [KEY_WIDTH-1:0] left,
	input  wire logic [KEY_WIDTH-1:0] right,
	output logic      [KEY_WIDTH-1:0] entry
);
	import sst_pkg::*;

	localparam logic [CNT_W-1:0] MY = CNT_W'(MY_IDX);

	logic [KEY_WIDTH-1:0] entry_q;
	logic                 at_pos;
	logic                 above_pos;
	logic                 in_use;
	logic                 before_last;

	assign at_pos      = (MY == pos);
	assign above_pos   = (MY > pos);
	assign in_use      = (MY <= cnt);
	assign before_last = (({1'b0, MY} + (CNT_W + 1)'(1)) < {1'b0, cnt});

	always_ff @(posedge clk) begin
		if (op.ins) begin
			if (at_pos) begin
				entry_q <= key_in;
			end else if (above_pos && in_use) begin
				entry_q <= left;
			end
		end else if (op.del) begin
			if ((at_pos || above_pos) && before_last) begin
				entry_q <= right;
			end
		end else if (op.wr) begin
			if (at_pos) begin
				entry_q <= key_in;
			end
		end
	end

	assign entry = entry_q;

endmodule

`default_nettype wire

@@ rtl/sst_array.sv @@
`default_nettype none

module sst_array #(
	parameter int CAPACITY  = 256,
	parameter int KEY_WIDTH = 32,
	parameter int CNT_W     = $clog2(CAPACITY + 1),
	parameter int IDX_W     = $clog2(CAPACITY)
) (
	input  wire logic                 clk,
	input  wire sst_pkg::sst_op_t     op,
	input  wire logic [CNT_W-1:0]     pos,
	input  wire logic [CNT_W-1:0]     cnt,
	input  wire logic [KEY_WIDTH-1:0] key_in,
	input  wire logic [IDX_W-1:0]     rd_addr,
	output logic      [KEY_WIDTH-1:0] rd_data
);
	import sst_pkg::*;

	logic [KEY_WIDTH-1:0] ent [CAPACITY];
	logic [KEY_WIDTH-1:0] rd_data_q;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [KEY_WIDTH-1:0] left_w;
		logic [KEY_WIDTH-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = ent[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = ent[i+1];
		end

		sst_cell #(
			.CNT_W     (CNT_W),
			.KEY_WIDTH (KEY_WIDTH),
			.MY_IDX    (i)
		) u_cell (
			.clk    (clk),
			.op     (op),
			.pos    (pos),
			.cnt    (cnt),
			.key_in (key_in),
			.left   (left_w),
			.right  (right_w),
			.entry  (ent[i])
		);
	end

	always_ff @(posedge clk) begin
		rd_data_q <= ent[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

@@ rtl/sorted_set_table.sv @@
`default_nettype none
// An add runs a binary search of at most log2(CAPACITY) + 1 CHECK, FETCH, COMPARE probes;
// a present key ends the search, a new key goes on through APPLY. Read fetches one entry, delete
// and replace go to APPLY, an out-of-range index skips to done; busy stays high until then.
// The next request is accepted at the earliest in the cycle after done; cells shift together.
// The result word is shown for one cycle with done high; the receiver cannot stall.
// Reset clears the count and control state; entries are undefined until written.

module sorted_set_table #(
	parameter int CAPACITY  = 256,
	parameter int KEY_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  kind,
	input  wire logic [31:0] key,
	input  wire logic [7:0]  index,
	output logic             done,
	output logic [1:0]       status,
	output logic [31:0]      data,
	output logic [8:0]       position,
	output logic [8:0]       count
);
	import sst_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int W     = (CNT_W > 9) ? CNT_W : 9;
	localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

	state_t               state_q;
	state_t               state_d;
	logic [CNT_W-1:0]     cnt_q;
	kind_t                kind_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [7:0]           idx_q;
	logic [CNT_W-1:0]     lo_q;
	logic [CNT_W-1:0]     hi_q;
	logic [IDX_W-1:0]     addr_q;
	status_t              status_q;
	logic [31:0]          data_q;
	logic [W-1:0]         pos_q;

	logic [CNT_W-1:0]     mid;
	logic                 in_range;
	logic                 full;
	logic                 searching;
	logic [KEY_WIDTH-1:0] rd_data;
	sst_op_t              op;
	logic [CNT_W-1:0]     op_pos;

	assign mid       = lo_q + ((hi_q - lo_q) >> 1);
	assign in_range  = (W'(idx_q) < W'(cnt_q));
	assign full      = (cnt_q == CAP);
	assign searching = (lo_q < hi_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (kind_q == KIND_ADD) begin
					state_d = searching ? ST_FETCH : ST_APPLY;
				end else if (!in_range) begin
					state_d = ST_FIN;
				end else if (kind_q == KIND_READ) begin
					state_d = ST_FETCH;
				end else begin
					state_d = ST_APPLY;
				end
			end
			ST_FETCH: state_d = ST_COMPARE;
			ST_COMPARE: begin
				if (kind_q == KIND_READ || rd_data == key_q) begin
					state_d = ST_FIN;
				end else begin
					state_d = ST_CHECK;
				end
			end
			ST_APPLY: state_d = ST_FIN;
			ST_FIN:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		op     = '0;
		op_pos = CNT_W'(idx_q);
		busy   = (state_q != ST_IDLE);
		done   = (state_q == ST_FIN);
		if (state_q == ST_APPLY) begin
			case (kind_q)
				KIND_ADD: begin
					op.ins = !full;
					op_pos = lo_q;
				end
				KIND_DELETE:  op.del = 1'b1;
				KIND_REPLACE: op.wr  = 1'b1;
				default:      op     = '0;
			endcase
		end
	end

	assign status   = status_q;
	assign data     = data_q;
	assign position = pos_q[8:0];
	assign count    = W'(cnt_q) & W'(9'h1FF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_APPLY) begin
				if (kind_q == KIND_ADD && !full) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end else if (kind_q == KIND_DELETE) begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					kind_q   <= kind_t'(kind);
					key_q    <= KEY_WIDTH'(key);
					idx_q    <= index;
					lo_q     <= '0;
					hi_q     <= cnt_q;
					status_q <= STATUS_OK;
					data_q   <= '0;
					pos_q    <= W'(index);
				end
			end
			ST_CHECK: begin
				addr_q <= (kind_q == KIND_ADD) ? IDX_W'(mid) : IDX_W'(idx_q);
				if (kind_q == KIND_ADD) begin
					if (!searching) begin
						pos_q <= W'(lo_q);
					end
				end else if (!in_range) begin
					status_q <= STATUS_RANGE;
				end
			end
			ST_COMPARE: begin
				if (kind_q == KIND_READ) begin
					data_q <= 32'(rd_data);
				end else if (rd_data == key_q) begin
					status_q <= STATUS_DUP;
					pos_q    <= W'(addr_q);
				end else if (rd_data < key_q) begin
					lo_q <= CNT_W'(addr_q) + CNT_W'(1);
				end else begin
					hi_q <= CNT_W'(addr_q);
				end
			end
			ST_APPLY: begin
				if (kind_q == KIND_ADD && full) begin
					status_q <= STATUS_FULL;
				end
			end
			default: begin
			end
		endcase
	end

	sst_array #(
		.CAPACITY  (CAPACITY),
		.KEY_WIDTH (KEY_WIDTH),
		.CNT_W     (CNT_W),
		.IDX_W     (IDX_W)
	) u_array (
		.clk     (clk),
		.op      (op),
		.pos     (op_pos),
		.cnt     (cnt_q),
		.key_in  (key_q),
		.rd_addr (addr_q),
		.rd_data (rd_data)
	);

endmodule

`default_nettype wire

@@ rtl/sst_checker.sv @@
`default_nettype none

module sst_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [1:0]  status,
	input wire logic [31:0] data
);
	import sst_pkg::*;

	a_done_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("Result word shown while the block is idle.");

	a_accept_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("Accepted word did not make the block busy.");

	a_done_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!done && !busy))
		else $error("Result strobe lasted more than one cycle.");

	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != STATUS_OK) |-> (data == 32'd0))
		else $error("Failed request returned nonzero data.");

endmodule

bind sorted_set_table sst_checker u_sst_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.status (status),
	.data   (data)
);

`default_nettype wire
